### hw/rtl/box_nms_suppressor_core_assert.svh
// Assertion macros for the box NMS suppressor checker.
// Included by the checker file; no other dependencies.
`ifndef BOX_NMS_SUPPRESSOR_CORE_ASSERT_SVH
`define BOX_NMS_SUPPRESSOR_CORE_ASSERT_SVH

// same-cycle implication
`define BNMS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bnms check failed");

// next-cycle implication
`define BNMS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bnms check failed");

`endif

### hw/rtl/bnms_pkg.sv
// Shared types and constants for the box NMS suppressor.
// No dependencies.
package bnms_pkg;

  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int OVL_W     = 19;
  localparam int INTER_W   = 34;
  localparam int UNION_W   = 36;
  localparam logic [15:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] objectness;
    logic [15:0] cls_score;
    logic        last_box;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  box_index;
    logic        kept;
    logic [15:0] final_objectness;
    logic        last_result;
  } out_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [15:0]      obj;
    logic [31:0]      score;
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [15:0]      w;
    logic [15:0]      h;
  } box_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic push;
  } cell_ctl_t;

  typedef struct packed {
    box_t box;
    logic valid;
    logic gt;
    logic after;
  } link_t;

endpackage

### hw/rtl/bnms_cell.sv
// One cell of the box chain: holds one box, sorted insert and ring rotation.
// Depends on bnms_pkg.
module bnms_cell import bnms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  box_t      new_box,
  input  box_t      push_box,
  input  link_t     prev,
  input  box_t      next_box,
  input  logic      next_valid,
  output link_t     link
);

  box_t box, box_next;
  logic valid, valid_next;
  logic gt, after, take_push;

  assign gt        = !valid || (new_box.score > box.score);
  assign after     = ctl.shift ? next_valid : valid;
  assign take_push = ctl.push && !after && prev.after;

  always_comb begin
    box_next   = box;
    valid_next = valid;
    if (ctl.ins) begin
      if (gt) begin
        box_next   = prev.gt ? prev.box : new_box;
        valid_next = prev.gt ? prev.valid : 1'b1;
      end
    end else begin
      if (ctl.shift) begin
        box_next   = next_box;
        valid_next = next_valid;
      end
      if (take_push) begin
        box_next   = push_box;
        valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    box <= box_next;
  end

  assign link = '{box: box, valid: valid, gt: gt, after: after};

endmodule

### hw/rtl/bnms_iou_unit.sv
// Pipelined overlap test against the current suppressor box.
// Depends on bnms_pkg.
module bnms_iou_unit import bnms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] thr,
  input  logic        sup_load,
  input  box_t        sup_box,
  input  logic        req_valid,
  input  logic        req_test,
  input  box_t        req_box,
  output logic        rsp_valid,
  output box_t        rsp_box,
  output logic        busy
);

  function automatic logic signed [OVL_W-1:0] ovl(input logic [15:0] c1, input logic [15:0] s1,
                                                  input logic [15:0] c2, input logic [15:0] s2);
    logic signed [OVL_W-1:0] l1, l2, r1, r2, lf, rt;
    l1 = $signed({2'b0, c1, 1'b0}) - $signed({3'b0, s1});
    l2 = $signed({2'b0, c2, 1'b0}) - $signed({3'b0, s2});
    r1 = $signed({2'b0, c1, 1'b0}) + $signed({3'b0, s1});
    r2 = $signed({2'b0, c2, 1'b0}) + $signed({3'b0, s2});
    lf = (l1 > l2) ? l1 : l2;
    rt = (r1 < r2) ? r1 : r2;
    return rt - lf;
  endfunction

  box_t sup;
  logic [31:0] area_a;

  logic v1, t1, v2, t2, v3, t3, v4, t4;
  box_t b1, b2, b3, b4, b4_res;
  logic signed [OVL_W-1:0] ow2, oh2;
  logic [INTER_W-1:0] inter3, inter4, inter_c;
  logic [31:0] area_b3;
  logic [UNION_W-1:0] union4;
  logic [51:0] lhs, rhs;
  logic hit;

  assign inter_c = (ow2 > 19'sd0 && oh2 > 19'sd0)
                 ? {17'b0, ow2[16:0]} * {17'b0, oh2[16:0]} : '0;
  assign lhs = {2'b0, inter4, 16'b0};
  assign rhs = {36'b0, thr} * {16'b0, union4};
  assign hit = t4 && (lhs > rhs);

  always_comb begin
    b4_res = b4;
    if (hit) begin
      b4_res.obj = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      rsp_valid <= v4;
    end
    if (sup_load) begin
      sup <= sup_box;
    end
    area_a <= {16'b0, sup.w} * {16'b0, sup.h};
    t1 <= req_test;
    b1 <= req_box;
    t2 <= t1;
    b2 <= b1;
    ow2 <= ovl(sup.cx, sup.w, b1.cx, b1.w);
    oh2 <= ovl(sup.cy, sup.h, b1.cy, b1.h);
    t3 <= t2;
    b3 <= b2;
    inter3 <= inter_c;
    area_b3 <= {16'b0, b2.w} * {16'b0, b2.h};
    t4 <= t3;
    b4 <= b3;
    inter4 <= inter3;
    union4 <= {2'b0, area_a, 2'b0} + {2'b0, area_b3, 2'b0} - {2'b0, inter3};
    rsp_box <= b4_res;
  end

  assign busy = v1 || v2 || v3 || v4 || rsp_valid;

endmodule

### hw/rtl/box_nms_suppressor_core.sv
// Box non-maximum suppression core: top level.
// Depends on bnms_pkg, bnms_cell and bnms_iou_unit.
// Boxes are taken one a cycle while loading and inserted, sorted by objectness times
// class score, into a chain of MAX_BOXES cells. After the final box the chain runs
// as a ring through a five-stage overlap unit: for n boxes there are n passes of n+1
// pops. Results then leave in arrival order by rotating the ring to each index in
// turn. Input is not taken from the final box until the last result is in the output
// register.
module box_nms_suppressor_core import bnms_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_req_t    res_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_SUPP = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  logic [1:0] phase;
  logic [CNT_W-1:0] n, pass, k, t;
  logic [15:0] thr;
  logic sup_live;

  link_t lk [MAX_BOXES];
  link_t prev_lk [MAX_BOXES];
  cell_ctl_t ctl;
  box_t new_box, push_box, head, u_box;
  logic head_v, in_acc, pop, opop, match, test, u_valid, u_busy;

  assign in_ready = (phase == PH_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign head     = lk[0].box;
  assign head_v   = lk[0].valid;

  always_comb begin
    new_box.idx   = n[IDX_W-1:0];
    new_box.obj   = in_data.objectness;
    new_box.score = {16'b0, in_data.objectness} * {16'b0, in_data.cls_score};
    new_box.cx    = in_data.center_x;
    new_box.cy    = in_data.center_y;
    new_box.w     = in_data.box_width;
    new_box.h     = in_data.box_height;
  end

  assign pop   = (phase == PH_SUPP) && head_v && (pass < n);
  assign opop  = (phase == PH_OUT) && head_v && (!out_valid || out_ready);
  assign match = (head.idx == t[IDX_W-1:0]);
  assign test  = (k != '0) && sup_live && (({1'b0, k} + {1'b0, pass}) < {1'b0, n});

  assign ctl.ins   = in_acc;
  assign ctl.shift = pop || opop;
  assign ctl.push  = u_valid || (opop && !match);
  assign push_box  = u_valid ? u_box : head;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_lk[i] = '{box: new_box, valid: 1'b1, gt: 1'b0, after: 1'b1};
    end else begin : g_rest
      assign prev_lk[i] = lk[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_tail
      bnms_cell u_cell (
        .clk, .rst, .ctl, .new_box, .push_box,
        .prev(prev_lk[i]), .next_box(new_box), .next_valid(1'b0), .link(lk[i])
      );
    end else begin : g_body
      bnms_cell u_cell (
        .clk, .rst, .ctl, .new_box, .push_box,
        .prev(prev_lk[i]), .next_box(lk[i+1].box), .next_valid(lk[i+1].valid),
        .link(lk[i])
      );
    end
  end

  bnms_iou_unit u_iou (
    .clk, .rst, .thr,
    .sup_load(pop && (k == '0)), .sup_box(head),
    .req_valid(pop), .req_test(pop && test), .req_box(head),
    .rsp_valid(u_valid), .rsp_box(u_box), .busy(u_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LOAD;
      n         <= '0;
      pass      <= '0;
      k         <= '0;
      t         <= '0;
      thr       <= THR_RESET;
      out_valid <= 1'b0;
      sup_live  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (opop && match) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && (k == '0)) begin
        sup_live <= (head.obj != '0);
      end
      unique case (phase)
        PH_LOAD: begin
          if (in_acc) begin
            n <= n + 1'b1;
            if (in_data.last_box || ((n + 1'b1) >= CNT_W'(MAX_BOXES))) begin
              phase <= PH_SUPP;
              pass  <= '0;
              k     <= '0;
            end
          end
        end
        PH_SUPP: begin
          if (pop) begin
            if (k == n) begin
              k    <= '0;
              pass <= pass + 1'b1;
            end else begin
              k <= k + 1'b1;
            end
          end else if ((pass == n) && !u_busy) begin
            phase <= PH_OUT;
            t     <= '0;
          end
        end
        PH_OUT: begin
          if (opop && match) begin
            t <= t + 1'b1;
            if ((t + 1'b1) == n) begin
              phase <= PH_LOAD;
              n     <= '0;
            end
          end
        end
        default: begin
          phase <= PH_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (opop && match) begin
      res_data.box_index        <= head.idx;
      res_data.kept             <= (head.obj != '0);
      res_data.final_objectness <= head.obj;
      res_data.last_result      <= ((t + 1'b1) == n);
    end
  end

endmodule

### hw/rtl/bnms_checker.sv
// Port-level checks for the box NMS suppressor, bound to the top level.
// Depends on bnms_pkg and box_nms_suppressor_core_assert.svh.
`include "box_nms_suppressor_core_assert.svh"

module bnms_checker import bnms_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input in_req_t     in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_req_t    res_data
);

  // stalled result holds
  `BNMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_data))
  // final request closes the set
  `BNMS_ASSERT_NXT(a_last_closes, in_valid && in_ready && in_data.last_box, !in_ready)
  // no new request while a set is still being delivered
  `BNMS_ASSERT_IMP(a_no_overlap, out_valid && !res_data.last_result, !in_ready)
  // kept flag follows objectness
  `BNMS_ASSERT_IMP(a_kept, out_valid, res_data.kept == (res_data.final_objectness != 16'd0))

endmodule

bind box_nms_suppressor_core bnms_checker u_bnms_checker (.*);
